FILE: rtl/fdee_pkg.sv
// Shared constants for the frame delta escape encoder.
// Stands alone; the encoder top level imports it.
package fdee_pkg;

  localparam int DEF_MAX_FRAME_PIXELS = 65536;

  localparam int PIXEL_W = 16;
  localparam int CODE_W  = 8;
  localparam int INDEX_W = 16;
  localparam int COUNT_W = 17;
  localparam int CFG_W   = 17;

  // Reset value of the frame length register.
  localparam int RESET_FRAME_PIXELS = 65536;

  // The escape tally saturates at its all-ones value.
  localparam logic [COUNT_W-1:0] TALLY_MAX = {COUNT_W{1'b1}};

endpackage

FILE: rtl/frame_delta_escape_encoder_top.sv
// Top level of the frame delta escape encoder: frame store, pixel counter,
// delta coder and output register. Depends on fdee_pkg.
//
// The encoder takes one 16-bit pixel per clock while in_stall is low and
// returns one coded item per pixel. When the output is not stalled, the coded
// item is registered at the clock edge after the one that accepts the pixel.
// The rate of one pixel per clock is set by the frame store, a single memory
// with one read and one write port: each pixel reads its reference on
// acceptance and writes itself back when it leaves the read stage, with the
// written value forwarded when the next pixel reads the same entry. After
// reset the frame store is cleared to zero, one entry per cycle; in_stall
// stays high until the clearing is done, while the frame length register can
// be written at any time. The frame length takes effect on the next pixel; 0
// acts as 1 and values above MAX_FRAME_PIXELS act as MAX_FRAME_PIXELS.
module frame_delta_escape_encoder_top
  import fdee_pkg::*;
#(
  parameter int MAX_FRAME_PIXELS = DEF_MAX_FRAME_PIXELS
) (
  input  logic                clk,
  input  logic                rst_n,

  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CFG_W-1:0]    cfg_data,

  input  logic                in_valid,
  output logic                in_stall,
  input  logic [PIXEL_W-1:0]  in_pixel,

  output logic                out_valid,
  input  logic                out_stall,
  output logic [CODE_W-1:0]   out_code_byte,
  output logic                out_escaped,
  output logic [INDEX_W-1:0]  out_escape_index,
  output logic [CODE_W-1:0]   out_escape_high_byte,
  output logic                out_frame_end,
  output logic [COUNT_W-1:0]  out_frame_escape_count
);

  localparam int PW = $clog2(MAX_FRAME_PIXELS);
  localparam int LW = (PW + 1 > CFG_W) ? PW + 1 : CFG_W;
  localparam int XW = (PW > INDEX_W) ? PW : INDEX_W;
  localparam int RESET_LEN = (RESET_FRAME_PIXELS > MAX_FRAME_PIXELS) ?
                             MAX_FRAME_PIXELS : RESET_FRAME_PIXELS;
  localparam logic [LW-1:0] MAX_LEN   = LW'(MAX_FRAME_PIXELS);
  localparam logic [PW-1:0] LAST_ADDR = PW'(MAX_FRAME_PIXELS - 1);

  // Frame store and its registered read port.
  logic [PIXEL_W-1:0] ref_mem [MAX_FRAME_PIXELS];
  logic [PIXEL_W-1:0] rd_r;

  // Control and datapath registers.
  logic               clr_r,       clr_nxt;
  logic [PW-1:0]      clr_cnt_r,   clr_cnt_nxt;
  logic [LW-1:0]      len_r,       len_nxt;
  logic [PW-1:0]      pos_r,       pos_nxt;
  logic               s1_v_r,      s1_v_nxt;
  logic [PW-1:0]      s1_pos_r;
  logic [PIXEL_W-1:0] s1_pix_r;
  logic               s1_last_r;
  logic               fwd_r;
  logic [PIXEL_W-1:0] fwd_pix_r;
  logic [COUNT_W-1:0] tally_r,     tally_nxt;
  logic               out_v_r,     out_v_nxt;
  logic [CODE_W-1:0]  code_r;
  logic               esc_r;
  logic [INDEX_W-1:0] idx_r;
  logic [CODE_W-1:0]  hi_r;
  logic               end_r;
  logic [COUNT_W-1:0] cnt_r;

  logic               in_acc;
  logic               s1_go;
  logic               last;
  logic [LW-1:0]      cfg_len;
  logic [PIXEL_W-1:0] ref_pix;
  logic [PIXEL_W:0]   diff;
  logic               esc;
  logic [COUNT_W-1:0] tally_inc;
  logic [XW-1:0]      pos_x;
  logic               mem_we;
  logic [PW-1:0]      mem_wa;
  logic [PIXEL_W-1:0] mem_wd;

  assign cfg_ready = 1'b1;

  // The stage holding the pixel whose reference is being read moves on when
  // the output register is empty or being emptied.
  assign s1_go    = s1_v_r && (!out_v_r || !out_stall);
  assign in_stall = clr_r || (s1_v_r && !s1_go);
  assign in_acc   = in_valid && !in_stall;

  assign last = ((LW'(pos_r) + LW'(1)) >= len_r);

  always_comb begin
    cfg_len = LW'(cfg_data);
    if (cfg_data == '0) begin
      cfg_len = LW'(1);
    end else if (cfg_len > MAX_LEN) begin
      cfg_len = MAX_LEN;
    end
  end

  // Delta against the stored pixel; escapes when it leaves the signed byte range.
  assign ref_pix   = fwd_r ? fwd_pix_r : rd_r;
  assign diff      = {1'b0, s1_pix_r} - {1'b0, ref_pix};
  assign esc       = !((diff[PIXEL_W:CODE_W-1] == '0) || (diff[PIXEL_W:CODE_W-1] == '1));
  assign tally_inc = (esc && tally_r != TALLY_MAX) ? tally_r + COUNT_W'(1) : tally_r;
  assign pos_x     = XW'(s1_pos_r);

  always_comb begin
    clr_nxt     = clr_r;
    clr_cnt_nxt = clr_cnt_r;
    if (clr_r) begin
      clr_cnt_nxt = clr_cnt_r + PW'(1);
      if (clr_cnt_r == LAST_ADDR) begin
        clr_nxt = 1'b0;
      end
    end
    len_nxt = (cfg_valid && cfg_ready) ? cfg_len : len_r;
    pos_nxt = pos_r;
    if (in_acc) begin
      pos_nxt = last ? '0 : pos_r + PW'(1);
    end
    s1_v_nxt  = in_acc || (s1_v_r && !s1_go);
    tally_nxt = tally_r;
    if (s1_go) begin
      tally_nxt = s1_last_r ? '0 : tally_inc;
    end
    out_v_nxt = s1_go || (out_v_r && out_stall);
  end

  always_comb begin
    if (clr_r) begin
      mem_we = 1'b1;
      mem_wa = clr_cnt_r;
      mem_wd = '0;
    end else begin
      mem_we = s1_go;
      mem_wa = s1_pos_r;
      mem_wd = s1_pix_r;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      ref_mem[mem_wa] <= mem_wd;
    end
    if (in_acc) begin
      rd_r <= ref_mem[pos_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r     <= 1'b1;
      clr_cnt_r <= '0;
      len_r     <= LW'(RESET_LEN);
      pos_r     <= '0;
      s1_v_r    <= 1'b0;
      tally_r   <= '0;
      out_v_r   <= 1'b0;
    end else begin
      clr_r     <= clr_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      len_r     <= len_nxt;
      pos_r     <= pos_nxt;
      s1_v_r    <= s1_v_nxt;
      tally_r   <= tally_nxt;
      out_v_r   <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_pos_r  <= pos_r;
      s1_pix_r  <= in_pixel;
      s1_last_r <= last;
      // The item ahead writes this same entry in this cycle, so the read
      // returns the old value; take the written pixel instead.
      fwd_r     <= s1_go && (s1_pos_r == pos_r);
      fwd_pix_r <= s1_pix_r;
    end
    if (s1_go) begin
      code_r <= esc ? s1_pix_r[CODE_W-1:0] : diff[CODE_W-1:0];
      esc_r  <= esc;
      idx_r  <= esc ? pos_x[INDEX_W-1:0] : '0;
      hi_r   <= esc ? s1_pix_r[PIXEL_W-1:CODE_W] : '0;
      end_r  <= s1_last_r;
      cnt_r  <= s1_last_r ? tally_inc : '0;
    end
  end

  assign out_valid              = out_v_r;
  assign out_code_byte          = code_r;
  assign out_escaped            = esc_r;
  assign out_escape_index       = idx_r;
  assign out_escape_high_byte   = hi_r;
  assign out_frame_end          = end_r;
  assign out_frame_escape_count = cnt_r;

  a_no_accept_while_clearing : assert property (@(posedge clk) disable iff (!rst_n)
    clr_r |-> !in_acc)
    else $error("pixel accepted during frame store clearing");

  a_held_item_stays : assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && !s1_go) |=> (s1_v_r && $stable(s1_pos_r) && $stable(s1_pix_r)))
    else $error("stalled pixel lost or changed in read stage");

  a_plain_fields_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !esc_r) |-> (idx_r == '0 && hi_r == '0))
    else $error("escape record fields set on a plain delta");

  a_count_only_at_end : assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !end_r) |-> (cnt_r == '0))
    else $error("escape count reported before frame end");

  a_pos_in_frame : assert property (@(posedge clk) disable iff (!rst_n)
    (LW'(pos_r) < MAX_LEN))
    else $error("pixel position beyond frame store");

endmodule
